[hdl/qtg_pkg.sv]
// types, codes and melody table for the queued tone generator
package qtg_pkg;

  typedef enum logic [1:0] {
    ACT_BEEP  = 2'd0,
    ACT_EVENT = 2'd1,
    ACT_TICK  = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    PLAY_IDLE = 2'd0,
    PLAY_TONE = 2'd1,
    PLAY_REST = 2'd2
  } play_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MEL,
    S_POP,
    S_DIV,
    S_OUT
  } state_e;

  localparam logic [2:0] EV_BOOT  = 3'd0;
  localparam logic [2:0] EV_RUN   = 3'd1;
  localparam logic [2:0] EV_STOP  = 3'd2;
  localparam logic [2:0] EV_CAL   = 3'd3;
  localparam logic [2:0] EV_ERROR = 3'd4;

  localparam int unsigned FREQ_W = 16;
  localparam int unsigned DUR_W  = 16;
  localparam int unsigned ENTRY_W = FREQ_W + DUR_W;
  localparam int unsigned LOST_W = 4;
  localparam int unsigned HP_W   = 19;
  localparam int unsigned PH_W   = 20;
  localparam int unsigned DEN_W  = FREQ_W + 1;

  localparam logic [PH_W-1:0] TONE_CLOCK = 20'd1000000;
  localparam logic [HP_W-1:0] MIN_HALF   = 19'd50;
  localparam logic [4:0]      DIV_STEPS  = 5'd20;

  localparam int unsigned MEL_ENTRIES = 28;

  localparam logic [ENTRY_W-1:0] MEL_ROM [MEL_ENTRIES] = '{
    // boot
    {16'd1047, 16'd55}, {16'd0, 16'd25}, {16'd1319, 16'd55}, {16'd0, 16'd25},
    {16'd1568, 16'd75}, {16'd0, 16'd25},
    // run start
    {16'd784, 16'd55}, {16'd0, 16'd25}, {16'd1047, 16'd70}, {16'd0, 16'd25},
    // stop
    {16'd1319, 16'd45}, {16'd0, 16'd25}, {16'd1047, 16'd75}, {16'd0, 16'd25},
    // calibration done
    {16'd1047, 16'd45}, {16'd0, 16'd25}, {16'd1319, 16'd45}, {16'd0, 16'd25},
    {16'd1568, 16'd45}, {16'd0, 16'd25}, {16'd2093, 16'd90}, {16'd0, 16'd25},
    // error
    {16'd392, 16'd130}, {16'd0, 16'd25}, {16'd0, 16'd90},
    {16'd392, 16'd130}, {16'd0, 16'd25}, {16'd0, 16'd90}
  };

  localparam logic [4:0] MEL_START [5] = '{5'd0, 5'd6, 5'd10, 5'd14, 5'd22};
  localparam logic [3:0] MEL_LEN   [5] = '{4'd6, 4'd4, 4'd4, 4'd8, 4'd6};

endpackage

[hdl/queued_tone_generator.sv]
// queued tone generator top level: command queue, melody loader and tone timer
//
// Input channel (in_valid_i / in_stall_o) carries one item: a beep command,
// an event melody request or a one microsecond tick. Each accepted item
// yields exactly one result on the output channel (out_valid_o /
// out_stall_i): pin level, busy flag, queue level and drop count.
// Items are handled one at a time in a small sequencer around the command
// queue memory (one write port, one registered read port).
// Path from accept to result valid: a beep, or a tick while playing or with
// an empty queue, goes straight to S_OUT; a melody request first passes
// S_MEL, which queues its notes; a tick that pops a command passes S_POP
// and, when a tone starts, the bit-serial half-period divider in S_DIV.
// The next item is accepted as soon as the sequencer is back in idle, even
// while the previous result still waits in the output register; a stalled
// receiver holds that result and, once a new one is ready, the sequencer.
// Reset clears queue pointers, timer and pin, and leaves the block disabled.
// Write cfg_enable_i through the cfg channel (always ready) while idle.
module queued_tone_generator
  import qtg_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH  = 24,
  parameter int unsigned TICKS_PER_MS = 1000
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic                cfg_enable_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          action_i,
  input  logic [FREQ_W-1:0]   freq_hz_i,
  input  logic [DUR_W-1:0]    duration_ms_i,
  input  logic [2:0]          event_code_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                pin_level_o,
  output logic                busy_res_o,
  output logic [4:0]          queue_count_o,
  output logic [LOST_W-1:0]   dropped_o
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned LVL_W = $clog2(QUEUE_DEPTH + 1);
  localparam longint unsigned MAX_US =
      64'd65535 * longint'(TICKS_PER_MS) + 64'd1000000;
  localparam int unsigned CNT_W = $clog2(MAX_US + 1);

  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [LVL_W-1:0] FULL_LVL = LVL_W'(QUEUE_DEPTH);

  logic [ENTRY_W-1:0] mem [QUEUE_DEPTH];
  logic [ENTRY_W-1:0] rdata_q;

  state_e             state_q, state_d;
  logic               enable_q;
  logic [PTR_W-1:0]   head_q, head_d, tail_q, tail_d;
  logic [LVL_W-1:0]   level_q, level_d;
  logic [HP_W-1:0]    hp_q, hp_d;
  logic [PH_W-1:0]    phase_q, phase_d;
  logic [CNT_W-1:0]   elapsed_q, elapsed_d, target_q, target_d;
  play_e              play_q, play_d;
  logic               pin_q, pin_d;
  logic [LOST_W-1:0]  lost_q, lost_d;
  logic [4:0]         idx_q, idx_d;
  logic [3:0]         rem_q, rem_d;
  logic [DEN_W-1:0]   div_rem_q, div_rem_d, div_den_q, div_den_d;
  logic [PH_W-1:0]    div_quo_q, div_quo_d;
  logic [4:0]         div_cnt_q, div_cnt_d;
  logic               out_valid_q;

  logic               wr_en, rd_en;
  logic [ENTRY_W-1:0] wdata;
  logic               full;
  logic               in_acc;
  logic               load_out;

  logic [CNT_W-1:0]   elapsed_inc;
  logic [PH_W-1:0]    phase_inc;
  logic               time_up;
  logic [DEN_W:0]     trial;
  logic [FREQ_W-1:0]  rd_freq;
  logic [DUR_W-1:0]   rd_dur;
  logic [HP_W-1:0]    quo_hp;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign full        = (level_q == FULL_LVL);
  assign out_valid_o = out_valid_q;
  assign load_out    = (state_q == S_OUT) && (!out_valid_q || !out_stall_i);

  assign elapsed_inc = elapsed_q + CNT_W'(1);
  assign phase_inc   = phase_q + PH_W'(1);
  assign time_up     = (elapsed_inc >= target_q);
  assign rd_freq     = rdata_q[ENTRY_W-1:DUR_W];
  assign rd_dur      = rdata_q[DUR_W-1:0];
  assign trial       = {div_rem_q, div_quo_q[PH_W-1]};

  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    tail_d    = tail_q;
    level_d   = level_q;
    hp_d      = hp_q;
    phase_d   = phase_q;
    elapsed_d = elapsed_q;
    target_d  = target_q;
    play_d    = play_q;
    pin_d     = pin_q;
    lost_d    = lost_q;
    idx_d     = idx_q;
    rem_d     = rem_q;
    div_rem_d = div_rem_q;
    div_den_d = div_den_q;
    div_quo_d = div_quo_q;
    div_cnt_d = div_cnt_q;
    wr_en     = 1'b0;
    rd_en     = 1'b0;
    wdata     = {freq_hz_i, duration_ms_i};
    quo_hp    = '0;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          lost_d  = '0;
          state_d = S_OUT;
          if (enable_q) begin
            case (action_i)
              ACT_BEEP: begin
                if (full) begin
                  lost_d = LOST_W'(1);
                end else begin
                  wr_en   = 1'b1;
                  tail_d  = (tail_q == LAST_PTR) ? '0 : tail_q + PTR_W'(1);
                  level_d = level_q + LVL_W'(1);
                end
              end
              ACT_EVENT: begin
                if (event_code_i inside {[EV_BOOT:EV_ERROR]}) begin
                  idx_d   = MEL_START[event_code_i];
                  rem_d   = MEL_LEN[event_code_i];
                  state_d = S_MEL;
                end
              end
              ACT_TICK: begin
                case (play_q)
                  PLAY_IDLE: begin
                    if (level_q != '0) begin
                      rd_en   = 1'b1;
                      head_d  = (head_q == LAST_PTR) ? '0 : head_q + PTR_W'(1);
                      level_d = level_q - LVL_W'(1);
                      state_d = S_POP;
                    end
                  end
                  PLAY_REST: begin
                    elapsed_d = elapsed_inc;
                    pin_d     = 1'b0;
                    if (time_up) play_d = PLAY_IDLE;
                  end
                  PLAY_TONE: begin
                    elapsed_d = elapsed_inc;
                    phase_d   = phase_inc;
                    if (phase_inc == PH_W'(hp_q)) begin
                      pin_d = 1'b0;
                    end else if (phase_inc >= {hp_q, 1'b0}) begin
                      if (time_up) begin
                        play_d = PLAY_IDLE;
                        pin_d  = 1'b0;
                      end else begin
                        phase_d = '0;
                        pin_d   = 1'b1;
                      end
                    end
                  end
                  default: ;
                endcase
              end
              default: ;
            endcase
          end
        end
      end
      S_MEL: begin
        wdata = MEL_ROM[idx_q];
        if (full) begin
          lost_d = lost_q + LOST_W'(1);
        end else begin
          wr_en   = 1'b1;
          tail_d  = (tail_q == LAST_PTR) ? '0 : tail_q + PTR_W'(1);
          level_d = level_q + LVL_W'(1);
        end
        idx_d = idx_q + 5'd1;
        rem_d = rem_q - 4'd1;
        if (rem_q == 4'd1) state_d = S_OUT;
      end
      S_POP: begin
        state_d = S_OUT;
        // zero duration is skipped and leaves the block idle
        if (rd_dur != '0) begin
          elapsed_d = '0;
          target_d  = CNT_W'(rd_dur) * CNT_W'(TICKS_PER_MS);
          if (rd_freq == '0) begin
            play_d = PLAY_REST;
            pin_d  = 1'b0;
          end else begin
            div_den_d = {rd_freq, 1'b0};
            div_rem_d = '0;
            div_quo_d = TONE_CLOCK;
            div_cnt_d = '0;
            state_d   = S_DIV;
          end
        end
      end
      S_DIV: begin
        // restoring division, one quotient bit per cycle
        if (trial >= {1'b0, div_den_q}) begin
          div_rem_d = DEN_W'(trial - {1'b0, div_den_q});
          div_quo_d = {div_quo_q[PH_W-2:0], 1'b1};
        end else begin
          div_rem_d = trial[DEN_W-1:0];
          div_quo_d = {div_quo_q[PH_W-2:0], 1'b0};
        end
        div_cnt_d = div_cnt_q + 5'd1;
        if (div_cnt_q == DIV_STEPS - 5'd1) begin
          quo_hp  = div_quo_d[HP_W-1:0];
          hp_d    = (quo_hp < MIN_HALF) ? MIN_HALF : quo_hp;
          phase_d = '0;
          play_d  = PLAY_TONE;
          pin_d   = 1'b1;
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (load_out) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      enable_q    <= 1'b0;
      head_q      <= '0;
      tail_q      <= '0;
      level_q     <= '0;
      hp_q        <= '0;
      phase_q     <= '0;
      elapsed_q   <= '0;
      target_q    <= '0;
      play_q      <= PLAY_IDLE;
      pin_q       <= 1'b0;
      lost_q      <= '0;
      idx_q       <= '0;
      rem_q       <= '0;
      div_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      if (cfg_valid_i && cfg_ready_o) enable_q <= cfg_enable_i;
      head_q    <= head_d;
      tail_q    <= tail_d;
      level_q   <= level_d;
      hp_q      <= hp_d;
      phase_q   <= phase_d;
      elapsed_q <= elapsed_d;
      target_q  <= target_d;
      play_q    <= play_d;
      pin_q     <= pin_d;
      lost_q    <= lost_d;
      idx_q     <= idx_d;
      rem_q     <= rem_d;
      div_cnt_q <= div_cnt_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // divider datapath and result payload
  always_ff @(posedge clk_i) begin
    div_rem_q <= div_rem_d;
    div_den_q <= div_den_d;
    div_quo_q <= div_quo_d;
    if (load_out) begin
      pin_level_o   <= pin_q & enable_q;
      busy_res_o    <= (play_q != PLAY_IDLE);
      queue_count_o <= 5'(level_q);
      dropped_o     <= lost_q;
    end
  end

  // command queue memory
  always_ff @(posedge clk_i) begin
    if (wr_en) mem[tail_q] <= wdata;
    if (rd_en) rdata_q <= mem[head_q];
  end

endmodule
